[hdl/mcst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcst_pkg
// Command and status codes, and the control/status bundles shared by the
// timer table controller and datapath.
// ----------------------------------------------------------------------------
package mcst_pkg;

    // command codes on kind
    localparam logic [2:0] KIND_CREATE  = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_STOP    = 3'd2;
    localparam logic [2:0] KIND_REMOVE  = 3'd3;
    localparam logic [2:0] KIND_QUERY   = 3'd4;
    localparam logic [2:0] KIND_PROCESS = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOT_USED = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;         // transaction accepted: latch inputs, clear scan
        logic exec_simple;  // start/stop/remove/query, executed at accept
        logic create_step;  // one slot of the free-slot search
        logic proc_step;    // one step of the expiry scan pipeline
        logic flush;        // emit the held fire result as the final one
    } mcst_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic free_hit;     // searched slot is free
        logic scan_end;     // searched slot is the last one
        logic pipe_done;    // expiry scan evaluates its last slot this cycle
    } mcst_stat_t;

endpackage
`default_nettype wire

[hdl/mcst_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcst_ctrl
// Sequencer for the timer table: dispatches commands and walks the create
// search and the process scan.
// ----------------------------------------------------------------------------
module mcst_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [2:0]         kind,
    input  wire mcst_pkg::mcst_stat_t stat,
    output mcst_pkg::mcst_ctrl_t    ctrl,
    output logic                    busy
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CREATE = 4'b0010,
        ST_PROC   = 4'b0100,
        ST_FLUSH  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load = 1'b1;
                    if (kind == mcst_pkg::KIND_CREATE)
                    begin
                        state_next = ST_CREATE;
                    end
                    else if (kind == mcst_pkg::KIND_PROCESS)
                    begin
                        state_next = ST_PROC;
                    end
                    else
                    begin
                        ctrl.exec_simple = 1'b1;
                    end
                end
            end
            ST_CREATE:
            begin
                ctrl.create_step = 1'b1;
                if (stat.free_hit || stat.scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PROC:
            begin
                ctrl.proc_step = 1'b1;
                if (stat.pipe_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                ctrl.flush = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/mcst_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcst_datapath
// Slot flags, start time / period memories, scan counter, expiry compare
// and the result register.
// ----------------------------------------------------------------------------
module mcst_datapath #(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mcst_pkg::mcst_ctrl_t ctrl,
    input  wire logic [2:0]           kind,
    input  wire logic [2:0]           timer_slot,
    input  wire logic [31:0]          period,
    input  wire logic                 once_mode,
    input  wire logic [31:0]          now,
    output mcst_pkg::mcst_stat_t      stat,
    output logic                      strobe,
    output logic [2:0]                slot,
    output logic                      fired,
    output logic                      running,
    output logic [1:0]                status,
    output logic                      last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    // slot flags
    logic [NUM_TIMERS-1:0] used_reg,    used_next;
    logic [NUM_TIMERS-1:0] started_reg, started_next;
    logic [NUM_TIMERS-1:0] once_reg,    once_next;

    // latched command operands
    logic [TIME_BITS-1:0] period_l_reg, period_l_next;
    logic [TIME_BITS-1:0] now_l_reg,    now_l_next;
    logic                 once_l_reg,   once_l_next;

    // scan counter and evaluate stage
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0] ev_idx_reg,   ev_idx_next;

    // held fire result, released when the next one is found or at flush
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_slot_reg,  pend_slot_next;

    // result register
    logic       strobe_reg,  strobe_next;
    logic [2:0] slot_reg,    slot_next;
    logic       fired_reg,   fired_next;
    logic       running_reg, running_next;
    logic [1:0] status_reg,  status_next;
    logic       last_reg,    last_next;

    // memories: one write port, one registered read port
    logic [TIME_BITS-1:0] start_mem  [NUM_TIMERS];
    logic [TIME_BITS-1:0] period_mem [NUM_TIMERS];
    logic [TIME_BITS-1:0] rd_start_reg;
    logic [TIME_BITS-1:0] rd_period_reg;
    logic                 mem_we;
    logic                 period_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_BITS-1:0] wr_start;
    logic [IDX_W-1:0]     rd_addr;

    logic [IDX_W-1:0]     sl_idx;
    logic                 sl_valid;
    logic [IDX_W-1:0]     scan_idx;
    logic [TIME_BITS-1:0] now_in;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expire;

    assign sl_idx   = IDX_W'(timer_slot);
    assign sl_valid = (32'(timer_slot) < NUM_TIMERS) && used_reg[sl_idx];
    assign scan_idx = cnt_reg[IDX_W-1:0];
    assign now_in   = TIME_BITS'(now);
    assign elapsed  = now_l_reg - rd_start_reg;
    assign expire   = used_reg[ev_idx_reg] && started_reg[ev_idx_reg]
                      && (elapsed > rd_period_reg);

    assign stat.free_hit  = !used_reg[scan_idx];
    assign stat.scan_end  = (cnt_reg == CNT_W'(NUM_TIMERS - 1));
    assign stat.pipe_done = (cnt_reg == CNT_W'(NUM_TIMERS));

    always_comb
    begin
        used_next       = used_reg;
        started_next    = started_reg;
        once_next       = once_reg;
        period_l_next   = period_l_reg;
        now_l_next      = now_l_reg;
        once_l_next     = once_l_reg;
        cnt_next        = cnt_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        strobe_next     = 1'b0;
        slot_next       = slot_reg;
        fired_next      = fired_reg;
        running_next    = running_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        period_we       = 1'b0;
        wr_addr         = sl_idx;
        wr_start        = now_in;
        rd_addr         = scan_idx;

        if (ctrl.load)
        begin
            period_l_next   = TIME_BITS'(period);
            now_l_next      = now_in;
            once_l_next     = once_mode;
            cnt_next        = '0;
            ev_valid_next   = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (ctrl.exec_simple)
        begin
            slot_next    = timer_slot;
            fired_next   = 1'b0;
            running_next = 1'b0;
            status_next  = sl_valid ? mcst_pkg::STAT_OK : mcst_pkg::STAT_NOT_USED;
            last_next    = 1'b1;
            unique case (kind)
                mcst_pkg::KIND_START:
                begin
                    strobe_next = 1'b1;
                    if (sl_valid)
                    begin
                        mem_we               = 1'b1;
                        started_next[sl_idx] = 1'b1;
                    end
                end
                mcst_pkg::KIND_STOP:
                begin
                    strobe_next = 1'b1;
                    if (sl_valid)
                    begin
                        started_next[sl_idx] = 1'b0;
                    end
                end
                mcst_pkg::KIND_REMOVE:
                begin
                    strobe_next = 1'b1;
                    if (sl_valid)
                    begin
                        used_next[sl_idx]    = 1'b0;
                        started_next[sl_idx] = 1'b0;
                        once_next[sl_idx]    = 1'b0;
                    end
                end
                mcst_pkg::KIND_QUERY:
                begin
                    strobe_next  = 1'b1;
                    running_next = sl_valid && started_reg[sl_idx];
                end
                default:
                begin
                    // undefined kinds: no effect, no result
                end
            endcase
        end

        if (ctrl.create_step)
        begin
            cnt_next     = cnt_reg + 1'b1;
            fired_next   = 1'b0;
            running_next = 1'b0;
            last_next    = 1'b1;
            if (!used_reg[scan_idx])
            begin
                mem_we                 = 1'b1;
                period_we              = 1'b1;
                wr_addr                = scan_idx;
                wr_start               = now_l_reg;
                used_next[scan_idx]    = 1'b1;
                started_next[scan_idx] = 1'b0;
                once_next[scan_idx]    = once_l_reg;
                strobe_next            = 1'b1;
                slot_next              = 3'(scan_idx);
                status_next            = mcst_pkg::STAT_OK;
            end
            else if (stat.scan_end)
            begin
                strobe_next = 1'b1;
                slot_next   = 3'd0;
                status_next = mcst_pkg::STAT_FULL;
            end
        end

        if (ctrl.proc_step)
        begin
            // read stage
            if (cnt_reg < CNT_W'(NUM_TIMERS))
            begin
                cnt_next      = cnt_reg + 1'b1;
                ev_valid_next = 1'b1;
                ev_idx_next   = scan_idx;
            end
            else
            begin
                ev_valid_next = 1'b0;
            end
            // evaluate stage
            if (ev_valid_reg && expire)
            begin
                mem_we   = 1'b1;
                wr_addr  = ev_idx_reg;
                wr_start = now_l_reg;
                if (once_reg[ev_idx_reg])
                begin
                    used_next[ev_idx_reg]    = 1'b0;
                    started_next[ev_idx_reg] = 1'b0;
                    once_next[ev_idx_reg]    = 1'b0;
                end
                if (pend_valid_reg)
                begin
                    strobe_next  = 1'b1;
                    slot_next    = 3'(pend_slot_reg);
                    fired_next   = 1'b1;
                    running_next = 1'b0;
                    status_next  = mcst_pkg::STAT_OK;
                    last_next    = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_slot_next  = ev_idx_reg;
            end
        end

        if (ctrl.flush)
        begin
            if (pend_valid_reg)
            begin
                strobe_next  = 1'b1;
                slot_next    = 3'(pend_slot_reg);
                fired_next   = 1'b1;
                running_next = 1'b0;
                status_next  = mcst_pkg::STAT_OK;
                last_next    = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            started_reg    <= '0;
            once_reg       <= '0;
            cnt_reg        <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            started_reg    <= started_next;
            once_reg       <= once_next;
            cnt_reg        <= cnt_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_l_reg  <= period_l_next;
        now_l_reg     <= now_l_next;
        once_l_reg    <= once_l_next;
        ev_idx_reg    <= ev_idx_next;
        pend_slot_reg <= pend_slot_next;
        slot_reg      <= slot_next;
        fired_reg     <= fired_next;
        running_reg   <= running_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_mem[wr_addr] <= wr_start;
        end
        if (period_we)
        begin
            period_mem[wr_addr] <= period_l_reg;
        end
        rd_start_reg  <= start_mem[rd_addr];
        rd_period_reg <= period_mem[rd_addr];
    end

    assign strobe  = strobe_reg;
    assign slot    = slot_reg;
    assign fired   = fired_reg;
    assign running = running_reg;
    assign status  = status_reg;
    assign last    = last_reg;

    // a running slot is always an allocated slot
    a_started_used: assert property (@(posedge clk) disable iff (!rst_n)
        ((started_reg & ~used_reg) == '0))
        else $error("started flag set on a free slot");

    // evaluate stage only follows a read issued by the scan
    a_ev_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> $past(ctrl.proc_step))
        else $error("evaluate stage valid without a scan read");

    // flush always drains the held fire result
    a_flush_drains: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.flush |=> !pend_valid_reg)
        else $error("held fire result survived flush");

    // fire results carry ok status and no query answer
    a_fire_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && fired_reg) |-> (status_reg == mcst_pkg::STAT_OK && !running_reg))
        else $error("fire result with bad status or running bit");

endmodule
`default_nettype wire

[hdl/multi_channel_soft_timer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_soft_timer
// Table of software timer slots with create/start/stop/remove/query commands
// and a process tick that reports expired slots.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low; kind selects the command, the other input ports are its operands.
//   Each result is presented for exactly one cycle with strobe high; last
//   marks the final result of a command. The receiver cannot stall, so the
//   block never waits on the result side.
// Timing:
//   start, stop, remove, query: executed in the accept cycle, result
//     registered in the next cycle, busy stays low (one command per cycle).
//   create: searches slots one per cycle from slot 0; busy until it finds
//     the first free slot or has searched the last one (table full).
//   process: one slot per cycle through the registered memory read port
//     into the evaluate stage, then a flush step that releases the final
//     fire result; busy throughout. A quiet tick gives no result.
// Reset:
//   Clears all slot flags and the sequencer; the start time and period
//   memories are not cleared and are written by create before use.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer #(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_BITS  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  kind,
    input  wire logic [2:0]  timer_slot,
    input  wire logic [31:0] period,
    input  wire logic        once_mode,
    input  wire logic [31:0] now,
    output logic             strobe,
    output logic [2:0]       slot,
    output logic             fired,
    output logic             running,
    output logic [1:0]       status,
    output logic             last
);

    mcst_pkg::mcst_ctrl_t ctrl;  // sequencer commands
    mcst_pkg::mcst_stat_t stat;  // search/scan status back to the sequencer

    mcst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    mcst_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .kind       (kind),
        .timer_slot (timer_slot),
        .period     (period),
        .once_mode  (once_mode),
        .now        (now),
        .stat       (stat),
        .strobe     (strobe),
        .slot       (slot),
        .fired      (fired),
        .running    (running),
        .status     (status),
        .last       (last)
    );

endmodule
`default_nettype wire
